### hw/rtl/esd_pkg.sv
`default_nettype none

package esd_pkg;

    // Field widths of the words on both channels.
    localparam int unsigned STAMP_W = 32;
    localparam int unsigned YEAR_W  = 12;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned MIN_W   = 6;
    localparam int unsigned SEC_W   = 6;

    // Internal widths: whole days since the epoch, day of the year, year offset.
    localparam int unsigned DAYS_W  = 16;
    localparam int unsigned YDAY_W  = 9;
    localparam int unsigned YOFS_W  = 8;
    localparam int unsigned LEAPS_W = 6;

    // Reciprocals for exact division by constants over the full input range.
    // (x >> 2) / 15 for a 30-bit value, shift 35.
    localparam logic [31:0] RECIP_15_HI = 32'd2290649225;
    // (x >> 2) / 15 for a 25-bit value, shift 29.
    localparam logic [25:0] RECIP_15_LO = 26'd35791395;
    // (x >> 3) / 3 for an 18-bit value, shift 20.
    localparam logic [18:0] RECIP_3     = 19'd349526;
    // x / 1461, x / 366 and x / 365 for 16-bit values, shifts 27, 25, 25.
    localparam logic [16:0] RECIP_1461  = 17'd91868;
    localparam logic [16:0] RECIP_366   = 17'd91679;
    localparam logic [16:0] RECIP_365   = 17'd91930;

    localparam logic [DAYS_W-1:0]  DAYS_COMMON = 16'd365;
    localparam logic [DAYS_W-1:0]  DAYS_QUAD   = 16'd1461;
    localparam logic [DAYS_W-1:0]  QUAD_LAST   = 16'd1460;
    localparam logic [YEAR_W-1:0]  BASE_YEAR   = 12'd1970;
    localparam logic [1:0]         LEAP_PHASE  = 2'd2;
    localparam logic [YDAY_W-1:0]  LEAP_DAY    = 9'd60;
    localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC   = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FEB_29  = 5'd29;
    localparam logic [DAY_W-1:0]   DAY_DEC_31  = 5'd31;
    localparam logic [SEC_W-1:0]   SECS_MIN    = 6'd60;
    localparam logic [HOUR_W-1:0]  HOURS_DAY   = 5'd24;

    // Day of the year before the first of each month in a common year.
    localparam logic [YDAY_W-1:0] MONTH_START [12] = '{
        9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    // Day count and time of day between the two halves of the pipeline.
    typedef struct packed {
        logic [DAYS_W-1:0] days;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
    } day_time_t;

    // Complete calendar result.
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
    } date_t;

endpackage

`default_nettype wire

### hw/rtl/esd_stamp_if.sv
`default_nettype none

interface esd_stamp_if;

    logic                        valid;
    logic                        ready;
    logic [esd_pkg::STAMP_W-1:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink (input valid, input epoch_seconds, output ready);

endinterface

`default_nettype wire

### hw/rtl/esd_date_if.sv
`default_nettype none

interface esd_date_if;

    logic                        valid;
    logic                        ready;
    logic [esd_pkg::YEAR_W-1:0]  cal_year;
    logic [esd_pkg::MONTH_W-1:0] cal_month;
    logic [esd_pkg::DAY_W-1:0]   day_of_month;
    logic [esd_pkg::HOUR_W-1:0]  hour_of_day;
    logic [esd_pkg::MIN_W-1:0]   minute_of_hour;
    logic [esd_pkg::SEC_W-1:0]   second_of_minute;

    modport source (
        output valid, output cal_year, output cal_month, output day_of_month,
        output hour_of_day, output minute_of_hour, output second_of_minute,
        input ready
    );
    modport sink (
        input valid, input cal_year, input cal_month, input day_of_month,
        input hour_of_day, input minute_of_hour, input second_of_minute,
        output ready
    );

endinterface

`default_nettype wire

### hw/rtl/esd_time_split.sv
`default_nettype none

module esd_time_split (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [esd_pkg::STAMP_W-1:0] epoch_seconds,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output esd_pkg::day_time_t               out_time
);

    // Stage registers.
    logic                      v1_reg, v2_reg, v3_reg;
    logic [26:0]               q1_reg;
    logic [5:0]                lo1_reg;
    logic [20:0]               q2_reg;
    logic [5:0]                lo2_reg;
    logic [esd_pkg::SEC_W-1:0] sec2_reg;
    esd_pkg::day_time_t        t3_reg;

    logic rdy1, rdy2, rdy3;

    logic [61:0]                prod1;
    logic [26:0]                q1_next;
    logic [11:0]                m60_a;
    logic [esd_pkg::SEC_W-1:0]  sec2_next;
    logic [50:0]                prod2;
    logic [20:0]                q2_next;
    logic [11:0]                m60_b;
    logic [36:0]                prod3;
    logic [esd_pkg::DAYS_W-1:0] days_next;
    logic [esd_pkg::HOUR_W-1:0] d24_low;
    esd_pkg::day_time_t         t3_next;

    // A stage takes a new word when it is empty or its word moves on.
    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // Stage 1: whole minutes, t / 60 taken as (t / 4) / 15.
    assign prod1   = 62'(epoch_seconds[31:2]) * 62'(esd_pkg::RECIP_15_HI);
    assign q1_next = prod1[61:35];

    // Stage 2: seconds from the low bits, then whole hours.
    assign m60_a     = 12'(q1_reg[5:0]) * 12'(esd_pkg::SECS_MIN);
    assign sec2_next = lo1_reg - m60_a[5:0];
    assign prod2     = 51'(q1_reg[26:2]) * 51'(esd_pkg::RECIP_15_LO);
    assign q2_next   = prod2[49:29];

    // Stage 3: minutes, whole days as (hours / 8) / 3, and the hour of the day.
    assign m60_b     = 12'(q2_reg[5:0]) * 12'(esd_pkg::SECS_MIN);
    assign prod3     = 37'(q2_reg[20:3]) * 37'(esd_pkg::RECIP_3);
    assign days_next = prod3[35:20];
    assign d24_low   = {days_next[0], 4'b0000} + {days_next[1:0], 3'b000};

    always_comb
    begin
        t3_next.days   = days_next;
        t3_next.hour   = q2_reg[4:0] - d24_low;
        t3_next.minute = lo2_reg - m60_b[5:0];
        t3_next.second = sec2_reg;
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Payload registers follow their stage's enable.
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            q1_reg  <= q1_next;
            lo1_reg <= epoch_seconds[5:0];
        end
        if (rdy2)
        begin
            q2_reg   <= q2_next;
            lo2_reg  <= q1_reg[5:0];
            sec2_reg <= sec2_next;
        end
        if (rdy3)
        begin
            t3_reg <= t3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_time  = t3_reg;

    // The remainders of the three divisions stay inside their ranges.
    a_hour_range : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_time.hour < esd_pkg::HOURS_DAY))
        else $error("hour of day out of range");

    a_min_sec_range : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_time.minute < esd_pkg::SECS_MIN &&
                       out_time.second < esd_pkg::SECS_MIN))
        else $error("minute or second out of range");

endmodule

`default_nettype wire

### hw/rtl/esd_date_split.sv
`default_nettype none

module esd_date_split (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire esd_pkg::day_time_t in_time,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output esd_pkg::date_t          out_date
);

    typedef struct packed {
        logic [esd_pkg::HOUR_W-1:0] hour;
        logic [esd_pkg::MIN_W-1:0]  minute;
        logic [esd_pkg::SEC_W-1:0]  second;
    } hms_t;

    logic v4_reg, v5_reg, v6_reg, v7_reg;
    logic rdy4, rdy5, rdy6, rdy7;

    // Stage 4 registers.
    logic [esd_pkg::DAYS_W-1:0]  d4_reg;
    logic [esd_pkg::LEAPS_W-1:0] leaps4_reg;
    logic [esd_pkg::YOFS_W-1:0]  y366_4_reg;
    hms_t                        hms4_reg;

    // Stage 5 registers.
    logic                        special5_reg;
    logic [esd_pkg::DAYS_W-1:0]  days2_5_reg;
    logic [esd_pkg::YOFS_W-1:0]  yq5_reg;
    logic [esd_pkg::YOFS_W-1:0]  y366_5_reg;
    hms_t                        hms5_reg;

    // Stage 6 registers.
    logic                        special6_reg;
    logic                        leapday6_reg;
    logic [esd_pkg::YEAR_W-1:0]  year6_reg;
    logic [esd_pkg::YDAY_W-1:0]  yday6_reg;
    hms_t                        hms6_reg;

    // Stage 7 is the output register.
    esd_pkg::date_t              date7_reg;

    logic [esd_pkg::DAYS_W-1:0]  dp4;
    logic [32:0]                 prod_leaps;
    logic [32:0]                 prod_y366;
    logic [esd_pkg::DAYS_W-1:0]  dp5;
    logic [esd_pkg::DAYS_W-1:0]  quad_base;
    logic [esd_pkg::DAYS_W-1:0]  quad_rem;
    logic [esd_pkg::DAYS_W-1:0]  days2_next;
    logic [32:0]                 prod_year;
    logic [esd_pkg::DAYS_W-1:0]  year_base;
    logic [esd_pkg::DAYS_W-1:0]  yday_full;
    logic [esd_pkg::YDAY_W-1:0]  yday0;
    logic                        leap6;
    logic [esd_pkg::YDAY_W-1:0]  yday6_next;
    logic [esd_pkg::YOFS_W-1:0]  yofs6;
    logic [esd_pkg::MONTH_W-1:0] mon_idx;
    logic [esd_pkg::YDAY_W-1:0]  mday_full;
    esd_pkg::date_t              date7_next;

    assign rdy7     = !v7_reg || out_ready;
    assign rdy6     = !v6_reg || rdy7;
    assign rdy5     = !v5_reg || rdy6;
    assign rdy4     = !v4_reg || rdy5;
    assign in_ready = rdy4;

    // Stage 4: leap days passed, and the year offset counted in 366-day years.
    assign dp4        = in_time.days + esd_pkg::DAYS_COMMON;
    assign prod_leaps = 33'(dp4) * 33'(esd_pkg::RECIP_1461);
    assign prod_y366  = 33'(in_time.days) * 33'(esd_pkg::RECIP_366);

    // Stage 5: spot the last day of a leap year, remove leap days, find the year.
    assign dp5        = d4_reg + esd_pkg::DAYS_COMMON;
    assign quad_base  = 16'(leaps4_reg) * esd_pkg::DAYS_QUAD;
    assign quad_rem   = dp5 - quad_base;
    assign days2_next = d4_reg - 16'(leaps4_reg);
    assign prod_year  = 33'(days2_next) * 33'(esd_pkg::RECIP_365);

    // Stage 6: year and day of the year, with the leap-year shift after 29 February.
    assign year_base = 16'(yq5_reg) * esd_pkg::DAYS_COMMON;
    assign yday_full = days2_5_reg - year_base + 16'd1;
    assign yday0     = yday_full[esd_pkg::YDAY_W-1:0];
    assign leap6     = (yq5_reg[1:0] == esd_pkg::LEAP_PHASE);
    assign yofs6     = special5_reg ? y366_5_reg : yq5_reg;

    always_comb
    begin
        if (leap6 && yday0 > esd_pkg::LEAP_DAY)
        begin
            yday6_next = yday0 - 9'd1;
        end
        else
        begin
            yday6_next = yday0;
        end
    end

    // Stage 7: month from the table of month starts, then the special dates.
    always_comb
    begin
        mon_idx = '0;
        for (int k = 1; k < 12; k++)
        begin
            if (yday6_reg > esd_pkg::MONTH_START[k])
            begin
                mon_idx = mon_idx + 4'd1;
            end
        end
    end

    assign mday_full = yday6_reg - esd_pkg::MONTH_START[mon_idx];

    always_comb
    begin
        date7_next.year   = year6_reg;
        date7_next.hour   = hms6_reg.hour;
        date7_next.minute = hms6_reg.minute;
        date7_next.second = hms6_reg.second;
        priority if (special6_reg)
        begin
            date7_next.month = esd_pkg::MONTH_DEC;
            date7_next.day   = esd_pkg::DAY_DEC_31;
        end
        else if (leapday6_reg)
        begin
            date7_next.month = esd_pkg::MONTH_FEB;
            date7_next.day   = esd_pkg::DAY_FEB_29;
        end
        else
        begin
            date7_next.month = mon_idx + 4'd1;
            date7_next.day   = mday_full[esd_pkg::DAY_W-1:0];
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            if (rdy4)
            begin
                v4_reg <= in_valid;
            end
            if (rdy5)
            begin
                v5_reg <= v4_reg;
            end
            if (rdy6)
            begin
                v6_reg <= v5_reg;
            end
            if (rdy7)
            begin
                v7_reg <= v6_reg;
            end
        end
    end

    // Payload registers follow their stage's enable.
    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            d4_reg          <= in_time.days;
            leaps4_reg      <= prod_leaps[32:27];
            y366_4_reg      <= prod_y366[32:25];
            hms4_reg.hour   <= in_time.hour;
            hms4_reg.minute <= in_time.minute;
            hms4_reg.second <= in_time.second;
        end
        if (rdy5)
        begin
            special5_reg <= (quad_rem == esd_pkg::QUAD_LAST);
            days2_5_reg  <= days2_next;
            yq5_reg      <= prod_year[32:25];
            y366_5_reg   <= y366_4_reg;
            hms5_reg     <= hms4_reg;
        end
        if (rdy6)
        begin
            special6_reg <= special5_reg;
            leapday6_reg <= leap6 && (yday0 == esd_pkg::LEAP_DAY);
            year6_reg    <= esd_pkg::BASE_YEAR + 12'(yofs6);
            yday6_reg    <= yday6_next;
            hms6_reg     <= hms5_reg;
        end
        if (rdy7)
        begin
            date7_reg <= date7_next;
        end
    end

    assign out_valid = v7_reg;
    assign out_date  = date7_reg;

    // The last day of a four-year cycle always falls in a leap year.
    a_special_leap : assert property (@(posedge clk) disable iff (!rst_n)
        (v6_reg && special6_reg) |-> (year6_reg[1:0] == 2'b00))
        else $error("year-end special case outside a leap year");

    // A word in the output register holds a real calendar date.
    a_date_range : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_date.month >= 4'd1 && out_date.month <= esd_pkg::MONTH_DEC &&
                       out_date.day >= 5'd1 && out_date.year >= esd_pkg::BASE_YEAR))
        else $error("calendar date out of range");

endmodule

`default_nettype wire

### hw/rtl/epoch_seconds_to_date.sv
`default_nettype none

// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 UTC into calendar
// year, month, day, hour, minute and second. Every fourth year counts as a leap
// year, so dates are right from 1970 through 2099 and follow the four-year rule
// beyond that up to 2106. The converter is a seven-stage pipeline: it accepts one
// word every clock cycle while back-pressure does not hold it. It is built from a
// chain of constant-reciprocal multipliers (three for the time of day, three for
// the year) and the month lookup, which has a stage of its own.
// Back-pressure on the output stalls the pipeline without loss; empty stages
// still fill while the output waits.
module epoch_seconds_to_date (
    input  wire logic   clk,
    input  wire logic   rst_n,
    esd_stamp_if.sink   stamp,
    esd_date_if.source  date
);

    logic               mid_valid;
    logic               mid_ready;
    esd_pkg::day_time_t mid_time;
    esd_pkg::date_t     result;

    // Seconds into whole days and time of day.
    esd_time_split u_time_split (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (stamp.valid),
        .in_ready      (stamp.ready),
        .epoch_seconds (stamp.epoch_seconds),
        .out_valid     (mid_valid),
        .out_ready     (mid_ready),
        .out_time      (mid_time)
    );

    // Whole days into year, month and day.
    esd_date_split u_date_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_time   (mid_time),
        .out_valid (date.valid),
        .out_ready (date.ready),
        .out_date  (result)
    );

    assign date.cal_year         = result.year;
    assign date.cal_month        = result.month;
    assign date.day_of_month     = result.day;
    assign date.hour_of_day      = result.hour;
    assign date.minute_of_hour   = result.minute;
    assign date.second_of_minute = result.second;

endmodule

`default_nettype wire
